[hdl/sb64_pkg.sv]
// Shared types, constants and the base64 alphabet function of the scrambled base64 encoder.
`timescale 1ns / 1ps

package sb64_pkg;

  // Only the low byte of the 32-bit keystream reaches the data, and the low byte of
  // x*214013+2531011 mod 2^32 depends only on the low byte of x, so the
  // generator runs on 8 bits: 214013 mod 256 = 0xFD, 2531011 mod 256 = 0xC3.
  localparam logic [7:0] KsSeed = 8'hAA;
  localparam logic [7:0] KsMul  = 8'hFD;
  localparam logic [7:0] KsAdd  = 8'hC3;

  localparam logic [7:0] PadChar = 8'h3D;  // '='

  localparam int unsigned GroupChars = 4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } byte_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       out_last;
  } char_t;

  // One finished group of four characters, handed from the grouping logic to the
  // output register.
  typedef struct packed {
    logic                        load;
    logic [GroupChars-1:0][7:0]  chars;
    logic                        last;
  } grp_t;

  // Map a 6-bit value to its base64 character.
  function automatic logic [7:0] b64_char(input logic [5:0] v);
    logic [7:0] ret;
    if (v inside {[6'd0 : 6'd25]}) begin
      ret = {2'b00, v} + 8'd65;
    end else if (v inside {[6'd26 : 6'd51]}) begin
      ret = {2'b00, v} + 8'd71;
    end else if (v inside {[6'd52 : 6'd61]}) begin
      ret = {2'b00, v} - 8'd4;
    end else if (v == 6'd62) begin
      ret = 8'd43;
    end else begin
      ret = 8'd47;
    end
    return ret;
  endfunction

endpackage

[hdl/sb64_group.sv]
// Keystream scrambling, byte grouping and character formation of the scrambled base64 encoder.
`timescale 1ns / 1ps

module sb64_group (
  input  logic           clk,
  input  logic           rst,
  input  logic           scramble_enable,
  input  logic           byte_valid,
  output logic           byte_stall,
  input  sb64_pkg::byte_t byte_data,
  input  logic           load_ok,
  output sb64_pkg::grp_t grp
);

  logic [7:0] ks;
  logic [7:0] ks_next;
  logic [1:0] fill;
  logic [7:0] held [2];

  logic       closes;
  logic       accept;
  logic [7:0] b;
  logic [7:0] c0;
  logic [7:0] c1;
  logic [7:0] c2;
  logic       full;

  // A fill of three never arises; treat its top bit as "two held".
  assign full   = fill[1];
  assign closes = full || byte_data.last_byte;

  // Only a closing byte needs room in the output register.
  assign byte_stall = closes && !load_ok;
  assign accept     = byte_valid && !byte_stall;

  assign b       = byte_data.data_byte ^ (scramble_enable ? ks : 8'h00);
  assign ks_next = 8'(ks * sb64_pkg::KsMul + sb64_pkg::KsAdd);

  always_comb begin
    c0 = (fill == 2'd0) ? b : held[0];
    c1 = (fill == 2'd1) ? b : (full ? held[1] : 8'h00);
    c2 = full ? b : 8'h00;

    grp.load     = accept && closes;
    grp.last     = byte_data.last_byte;
    grp.chars[0] = sb64_pkg::b64_char(c0[7:2]);
    grp.chars[1] = sb64_pkg::b64_char({c0[1:0], c1[7:4]});
    grp.chars[2] = (fill != 2'd0) ? sb64_pkg::b64_char({c1[3:0], c2[7:6]})
                                  : sb64_pkg::PadChar;
    grp.chars[3] = full ? sb64_pkg::b64_char(c2[5:0]) : sb64_pkg::PadChar;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ks   <= sb64_pkg::KsSeed;
      fill <= 2'd0;
    end else if (accept) begin
      ks <= byte_data.last_byte ? sb64_pkg::KsSeed : ks_next;
      if (closes) begin
        fill <= 2'd0;
      end else begin
        fill <= fill + 2'd1;
      end
    end
  end

  // Held bytes are stored after scrambling; no reset.
  always_ff @(posedge clk) begin
    if (accept && !closes) begin
      held[fill[0]] <= b;
    end
  end

  a_fill_range: assert property (@(posedge clk) disable iff (rst) fill != 2'd3)
    else $error("group fill reached three");

  a_reseed: assert property (@(posedge clk) disable iff (rst)
    accept && byte_data.last_byte |=> ks == sb64_pkg::KsSeed && fill == 2'd0)
    else $error("keystream or fill not restarted after last byte");

  a_room: assert property (@(posedge clk) disable iff (rst) grp.load |-> load_ok)
    else $error("group closed with no room in output register");

endmodule

[hdl/sb64_serializer.sv]
// Output register that sends one finished group as four character transfers.
`timescale 1ns / 1ps

module sb64_serializer (
  input  logic            clk,
  input  logic            rst,
  input  sb64_pkg::grp_t  grp,
  output logic            load_ok,
  output logic            char_valid,
  input  logic            char_stall,
  output sb64_pkg::char_t char_data
);

  logic [7:0] chars [sb64_pkg::GroupChars];
  logic       last;
  logic [1:0] idx;
  logic       valid;
  logic       char_accept;
  logic       final_char;

  assign char_accept = valid && !char_stall;
  assign final_char  = idx == 2'(sb64_pkg::GroupChars - 1);
  assign load_ok     = !valid || (char_accept && final_char);

  assign char_valid         = valid;
  assign char_data.out_char = chars[idx];
  assign char_data.out_last = last && final_char;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      idx   <= 2'd0;
    end else if (grp.load) begin
      valid <= 1'b1;
      idx   <= 2'd0;
    end else if (char_accept) begin
      if (final_char) begin
        valid <= 1'b0;
      end
      idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (grp.load) begin
      for (int i = 0; i < sb64_pkg::GroupChars; i++) begin
        chars[i] <= grp.chars[i];
      end
      last <= grp.last;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    grp.load && valid |-> char_accept && final_char)
    else $error("group loaded over unsent characters");

  a_mid_group: assert property (@(posedge clk) disable iff (rst)
    char_accept && !final_char |=> valid && idx == $past(idx) + 2'd1)
    else $error("group dropped before its fourth character");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    char_valid && char_stall |=> char_valid && $stable(char_data))
    else $error("stalled character changed or vanished");

endmodule

[hdl/scrambled_base64_encoder_unit.sv]
// Top level of the scrambled base64 encoder: config register, grouping logic and output register.
`timescale 1ns / 1ps

// Scrambled base64 encoder. Message bytes arrive one per transfer on the byte
// channel, the final byte flagged by last_byte. With scramble_enable set, each
// byte is XORed with the low byte of a linear congruential keystream that starts
// at 0xaa for every message and steps after every byte (enabled or not). Bytes
// are grouped in threes; each group, and the short group closed by the last
// byte, becomes four base64 characters ('=' padding for a short group), sent one
// per transfer on the char channel, with out_last on the fourth character of the
// last group. Timing: a byte that does not close a group is never stalled and
// yields nothing. A closing byte is taken in the cycle the output register is
// free (empty, or its fourth character being taken); its first character is
// offered the next cycle. The output register sets the rate, one character per
// cycle while char_stall is low; a message of n bytes yields 4*ceil(n/3)
// characters. Write scramble_enable through the cfg channel (always ready) only
// between messages, with no characters pending; the new value applies from the
// next byte.
module scrambled_base64_encoder_unit (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic            cfg_data,
  input  logic            byte_valid,
  output logic            byte_stall,
  input  sb64_pkg::byte_t byte_data,
  output logic            char_valid,
  input  logic            char_stall,
  output sb64_pkg::char_t char_data
);

  logic           scramble_enable;
  logic           load_ok;
  sb64_pkg::grp_t grp;

  // Config register: take every write at once.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      scramble_enable <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      scramble_enable <= cfg_data;
    end
  end

  // Scramble, hold bytes until a group closes, and form its four characters.
  sb64_group u_group (
    .clk             (clk),
    .rst             (rst),
    .scramble_enable (scramble_enable),
    .byte_valid      (byte_valid),
    .byte_stall      (byte_stall),
    .byte_data       (byte_data),
    .load_ok         (load_ok),
    .grp             (grp)
  );

  // Hold the finished group and send it one character per transfer.
  sb64_serializer u_serializer (
    .clk        (clk),
    .rst        (rst),
    .grp        (grp),
    .load_ok    (load_ok),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_data  (char_data)
  );

endmodule
